/* src/assert_macros.svh */
// Assertion macros used by the top level of the convolution core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/cce_pkg.sv */
// Shared types and constants of the clamp-to-edge convolution core.
`default_nettype none

package cce_pkg;

    // Word field widths
    localparam int ACTION_W  = 2;
    localparam int TAP_IDX_W = 6;
    localparam int ROW_W     = 10;
    localparam int COL_W     = 4;
    localparam int VALUE_W   = 16;
    localparam int SUM_W     = 37;
    localparam int PROD_W    = 2 * VALUE_W;

    // Configuration register widths
    localparam int ROW_CNT_W  = 11;
    localparam int COL_CNT_W  = 5;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    // Command queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TAP  = 2'd0,
        ACT_PIX  = 2'd1,
        ACT_CONV = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 1'b0,
        CFG_COL_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_action                   op;
        logic [TAP_IDX_W-1:0]      tap_index;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic start;
        logic done;
    } t_bstat;

endpackage

`default_nettype wire

/* src/cce_front.sv */
// Front end: accepts input words, drops the ignored ones, queues commands.
`default_nettype none

module cce_front #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLS    = 16,
    parameter int KERNEL_SIZE = 5
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_push,
    output logic                                       o_full,
    input  wire logic [cce_pkg::ACTION_W-1:0]          i_action,
    input  wire logic [cce_pkg::TAP_IDX_W-1:0]         i_tap_index,
    input  wire logic [cce_pkg::ROW_W-1:0]             i_row,
    input  wire logic [cce_pkg::COL_W-1:0]             i_col,
    input  wire logic signed [cce_pkg::VALUE_W-1:0]    i_value,
    output logic                                       o_cmd_valid,
    output cce_pkg::t_cmd                              o_cmd,
    input  wire logic                                  i_cmd_pop
);
    import cce_pkg::*;

    localparam int TAPS = KERNEL_SIZE * KERNEL_SIZE;
    localparam int QPW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_q [QUEUE_DEPTH];
    logic [QPW-1:0]  r_wr_ptr;
    logic [QPW-1:0]  r_rd_ptr;
    logic [QCW-1:0]  r_count;

    logic   w_keep;
    t_cmd   w_cmd;
    logic   w_wr;
    logic   w_rd;

    always_comb begin
        w_cmd.op        = t_action'(i_action);
        w_cmd.tap_index = i_tap_index;
        w_cmd.row       = i_row;
        w_cmd.col       = i_col;
        w_cmd.value     = i_value;
        case (i_action)
            ACT_TAP: begin
                w_keep = (32'(i_tap_index) < 32'(TAPS));
            end
            ACT_PIX: begin
                w_keep = (32'(i_row) < 32'(MAX_ROWS)) && (32'(i_col) < 32'(MAX_COLS));
            end
            ACT_CONV: begin
                w_keep = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_full      = (r_count == QCW'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    // Drop words that do nothing; they are still accepted.
    assign w_wr = i_push && !o_full && w_keep;
    assign w_rd = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* src/cce_back.sv */
// Back end: kernel and pixel stores, tap sequencer, MAC pipeline, result register.
`default_nettype none

module cce_back #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLS    = 16,
    parameter int KERNEL_SIZE = 5
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cmd_valid,
    input  cce_pkg::t_cmd                           i_cmd,
    output logic                                    o_cmd_pop,
    input  wire logic [cce_pkg::ROW_CNT_W-1:0]      i_row_count,
    input  wire logic [cce_pkg::COL_CNT_W-1:0]      i_col_count,
    output logic                                    o_out_valid,
    output logic [cce_pkg::ROW_W-1:0]               o_out_row,
    output logic [cce_pkg::COL_W-1:0]               o_out_col,
    output logic signed [cce_pkg::SUM_W-1:0]        o_sum,
    input  wire logic                               i_out_pop,
    output cce_pkg::t_bstat                         o_stat
);
    import cce_pkg::*;

    localparam int TAPS      = KERNEL_SIZE * KERNEL_SIZE;
    localparam int TW        = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PIX_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW        = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int KW        = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
    localparam int HALF      = KERNEL_SIZE / 2;
    localparam int NRW       = ROW_CNT_W + 1;
    localparam int NCW       = COL_CNT_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state r_state;

    // Stores
    logic signed [VALUE_W-1:0] r_pix_mem [PIX_DEPTH];
    logic signed [VALUE_W-1:0] r_tap_mem [TAPS];

    // Latched request
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic [ROW_CNT_W-1:0] r_rlast;
    logic [COL_CNT_W-1:0] r_clast;

    // Tap walk
    logic [KW-1:0] r_kr;
    logic [KW-1:0] r_kc;
    logic [TW-1:0] r_tap;

    // Pipeline
    logic                      r_s1_valid, r_s1_first, r_s1_last;
    logic [ROW_CNT_W-1:0]      r_s1_x;
    logic [COL_CNT_W-1:0]      r_s1_y;
    logic [TW-1:0]             r_s1_tap;
    logic                      r_s2_valid, r_s2_first, r_s2_last;
    logic signed [VALUE_W-1:0] r_pix_q;
    logic signed [VALUE_W-1:0] r_tap_q;
    logic                      r_s3_valid, r_s3_first, r_s3_last;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_acc;

    logic                      r_out_valid;
    logic [ROW_W-1:0]          r_out_row;
    logic [COL_W-1:0]          r_out_col;
    logic signed [SUM_W-1:0]   r_out_sum;

    logic                      w_pop;
    logic                      w_start;
    logic                      w_pix_we;
    logic                      w_tap_we;
    logic [ROW_CNT_W-1:0]      w_rlast;
    logic [COL_CNT_W-1:0]      w_clast;
    logic signed [NRW-1:0]     w_nr;
    logic signed [NCW-1:0]     w_nc;
    logic [ROW_CNT_W-1:0]      w_x;
    logic [COL_CNT_W-1:0]      w_y;
    logic                      w_kc_end;
    logic                      w_last;
    logic [31:0]               w_wr_addr32;
    logic [31:0]               w_rd_addr32;
    logic [AW-1:0]             w_wr_addr;
    logic [AW-1:0]             w_rd_addr;
    logic signed [SUM_W-1:0]   w_acc_next;
    logic                      w_done;

    // Effective clamp bounds, as last valid index
    always_comb begin
        if (i_row_count == '0) begin
            w_rlast = '0;
        end else if (32'(i_row_count) > 32'(MAX_ROWS)) begin
            w_rlast = ROW_CNT_W'(MAX_ROWS - 1);
        end else begin
            w_rlast = i_row_count - 1'b1;
        end
        if (i_col_count == '0) begin
            w_clast = '0;
        end else if (32'(i_col_count) > 32'(MAX_COLS)) begin
            w_clast = COL_CNT_W'(MAX_COLS - 1);
        end else begin
            w_clast = i_col_count - 1'b1;
        end
    end

    // Command dispatch
    always_comb begin
        w_pop = 1'b0;
        if (r_state == ST_IDLE && i_cmd_valid) begin
            // Hold a convolution until the result slot is free.
            w_pop = (i_cmd.op != ACT_CONV) || !r_out_valid;
        end
    end

    assign o_cmd_pop = w_pop;
    assign w_start   = w_pop && (i_cmd.op == ACT_CONV);
    assign w_pix_we  = w_pop && (i_cmd.op == ACT_PIX);
    assign w_tap_we  = w_pop && (i_cmd.op == ACT_TAP);

    // Neighbor coordinates, clamped to the bounds
    always_comb begin
        w_nr = NRW'(r_row) + NRW'(r_kr) - NRW'(HALF);
        w_nc = NCW'(r_col) + NCW'(r_kc) - NCW'(HALF);
        if (w_nr < 0) begin
            w_x = '0;
        end else if (w_nr > $signed({1'b0, r_rlast})) begin
            w_x = r_rlast;
        end else begin
            w_x = w_nr[ROW_CNT_W-1:0];
        end
        if (w_nc < 0) begin
            w_y = '0;
        end else if (w_nc > $signed({2'b00, r_clast})) begin
            w_y = r_clast;
        end else begin
            w_y = w_nc[COL_CNT_W-1:0];
        end
    end

    assign w_kc_end = (r_kc == KW'(KERNEL_SIZE - 1));
    assign w_last   = w_kc_end && (r_kr == KW'(KERNEL_SIZE - 1));

    assign w_wr_addr32 = 32'(i_cmd.row) * 32'(MAX_COLS) + 32'(i_cmd.col);
    assign w_rd_addr32 = 32'(r_s1_x) * 32'(MAX_COLS) + 32'(r_s1_y);
    assign w_wr_addr   = w_wr_addr32[AW-1:0];
    assign w_rd_addr   = w_rd_addr32[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_pix_we) begin
            r_pix_mem[w_wr_addr] <= i_cmd.value;
        end
        r_pix_q <= r_pix_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_tap_we) begin
            r_tap_mem[i_cmd.tap_index[TW-1:0]] <= i_cmd.value;
        end
        r_tap_q <= r_tap_mem[r_s1_tap];
    end

    assign w_acc_next = (r_s3_first ? SUM_W'(0) : r_acc) + SUM_W'(r_prod);
    assign w_done     = r_s3_valid && r_s3_last;

    // Sequencer and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            case (r_state)
                ST_IDLE: begin
                    if (w_start) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_s1_valid <= 1'b1;
                    if (w_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (i_out_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_row   <= i_cmd.row;
            r_col   <= i_cmd.col;
            r_rlast <= w_rlast;
            r_clast <= w_clast;
            r_kr    <= '0;
            r_kc    <= '0;
            r_tap   <= '0;
        end else if (r_state == ST_RUN) begin
            r_tap <= r_tap + 1'b1;
            if (w_kc_end) begin
                r_kc <= '0;
                r_kr <= r_kr + 1'b1;
            end else begin
                r_kc <= r_kc + 1'b1;
            end
        end
        r_s1_x     <= w_x;
        r_s1_y     <= w_y;
        r_s1_tap   <= r_tap;
        r_s1_first <= (r_tap == '0);
        r_s1_last  <= w_last;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s3_first <= r_s2_first;
        r_s3_last  <= r_s2_last;
        r_prod     <= r_pix_q * r_tap_q;
        if (r_s3_valid) begin
            r_acc <= w_acc_next;
        end
        if (w_done) begin
            r_out_row <= r_row;
            r_out_col <= r_col;
            r_out_sum <= w_acc_next;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_sum        = r_out_sum;
    assign o_stat.start = w_start;
    assign o_stat.done  = w_done;

endmodule

`default_nettype wire

/* src/conv2d_clamp_edge_core.sv */
// Top level of the clamp-to-edge 2D convolution core.
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ---------------------------------------
//  input     push / full               i_action i_tap_index i_row i_col i_value
//  result    empty / pop               o_out_row o_out_col o_sum
//  config    i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// Tap and pixel writes are taken by the back end while it is idle; a convolution
// request walks the KERNEL_SIZE*KERNEL_SIZE taps, one MAC per tap through a single
// multiplier fed by the pixel and tap memory read ports.
// A request waits in the command queue while the result register is occupied;
// writes behind it still wait their turn. Reset is synchronous, active low;
// the stores hold no reset and need no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module conv2d_clamp_edge_core #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLS    = 16,
    parameter int KERNEL_SIZE = 5
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [cce_pkg::ACTION_W-1:0]        i_action,
    input  wire logic [cce_pkg::TAP_IDX_W-1:0]       i_tap_index,
    input  wire logic [cce_pkg::ROW_W-1:0]           i_row,
    input  wire logic [cce_pkg::COL_W-1:0]           i_col,
    input  wire logic signed [cce_pkg::VALUE_W-1:0]  i_value,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [cce_pkg::ROW_W-1:0]                o_out_row,
    output logic [cce_pkg::COL_W-1:0]                o_out_col,
    output logic signed [cce_pkg::SUM_W-1:0]         o_sum,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [cce_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [cce_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cce_pkg::*;

    logic [ROW_CNT_W-1:0] r_row_count;
    logic [COL_CNT_W-1:0] r_col_count;

    logic   w_cmd_valid;
    t_cmd   w_cmd;
    logic   w_cmd_pop;
    logic   w_out_valid;
    t_bstat w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_CNT_W'(1024);
            r_col_count <= COL_CNT_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROW_COUNT: begin
                    r_row_count <= i_cfg_data[ROW_CNT_W-1:0];
                end
                CFG_COL_COUNT: begin
                    r_col_count <= i_cfg_data[COL_CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    cce_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_action    (i_action),
        .i_tap_index (i_tap_index),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    cce_back #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_row_count (r_row_count),
        .i_col_count (r_col_count),
        .o_out_valid (w_out_valid),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_sum       (o_sum),
        .i_out_pop   (pop),
        .o_stat      (w_stat)
    );

    assign empty = !w_out_valid;

    // A convolution starts only with the result register free.
    `ASSERT_ALWAYS(a_start_slot_free, i_clk, i_rst_n, !w_stat.start || empty)
    // The last MAC fills the result register.
    `ASSERT_NEXT(a_done_fills_slot, i_clk, i_rst_n, w_stat.done, !empty)
    // Queue head holds until the back end takes it.
    `ASSERT_NEXT(a_cmd_hold, i_clk, i_rst_n, w_cmd_valid && !w_cmd_pop,
                 w_cmd_valid && $stable(w_cmd))

endmodule

`default_nettype wire

/* test/tb_conv2d_clamp_edge_core.sv */
// Self-checking testbench for the clamp-to-edge 2D convolution core.
`timescale 1ns / 100ps

module tb_conv2d_clamp_edge_core;
    import cce_pkg::*;

    localparam int MAX_ROWS      = 1024;
    localparam int MAX_COLS      = 16;
    localparam int KSIZE         = 5;
    localparam int KHALF         = KSIZE / 2;
    localparam int TAPS          = KSIZE * KSIZE;
    localparam int SETTLE_CYCLES = TAPS + 12;
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [SUM_W-1:0] sum;
    } conv_result_t;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       push        = 1'b0;
    logic                       full;
    logic [ACTION_W-1:0]        i_action    = '0;
    logic [TAP_IDX_W-1:0]       i_tap_index = '0;
    logic [ROW_W-1:0]           i_row       = '0;
    logic [COL_W-1:0]           i_col       = '0;
    logic signed [VALUE_W-1:0]  i_value     = '0;
    logic                       empty;
    logic                       pop         = 1'b0;
    logic [ROW_W-1:0]           o_out_row;
    logic [COL_W-1:0]           o_out_col;
    logic signed [SUM_W-1:0]    o_sum;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;

    // Shadow of the block's state
    logic signed [VALUE_W-1:0]  pix_mem [0:MAX_ROWS*MAX_COLS-1];
    logic                       pix_written [0:MAX_ROWS*MAX_COLS-1];
    logic signed [VALUE_W-1:0]  tap_mem [0:TAPS-1];
    logic [ROW_CNT_W-1:0]       row_cnt_reg = 11'd1024;
    logic [COL_CNT_W-1:0]       col_cnt_reg = 5'd16;

    conv_result_t conv_expect_q[$];

    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int err_count     = 0;
    int n_conv        = 0;
    int n_write       = 0;
    int n_ignored     = 0;
    int n_settings    = 0;

    conv2d_clamp_edge_core #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .KERNEL_SIZE (KSIZE)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_action    (i_action),
        .i_tap_index (i_tap_index),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .empty       (empty),
        .pop         (pop),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_sum       (o_sum),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int effective_bound(int cnt, int maxv);
        if (cnt < 1) return 1;
        if (cnt > maxv) return maxv;
        return cnt;
    endfunction

    function automatic int clip_to_edge(int v, int bound);
        if (v < 0) return 0;
        if (v >= bound) return bound - 1;
        return v;
    endfunction

    function automatic logic [SUM_W-1:0] predict_conv_sum(int row, int col);
        int     rb;
        int     cb;
        int     x;
        int     y;
        longint acc;
        rb  = effective_bound(row_cnt_reg, MAX_ROWS);
        cb  = effective_bound(col_cnt_reg, MAX_COLS);
        acc = 0;
        for (int r = 0; r < KSIZE; r++) begin
            x = clip_to_edge(row + r - KHALF, rb);
            for (int c = 0; c < KSIZE; c++) begin
                y = clip_to_edge(col + c - KHALF, cb);
                acc += longint'(pix_mem[x*MAX_COLS + y]) * longint'(tap_mem[r*KSIZE + c]);
            end
        end
        return acc[SUM_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] rand16();
        return VALUE_W'($urandom());
    endfunction

    // Favor rows around the top edge, the bottom bound and the middle
    function automatic logic [ROW_W-1:0] pick_row();
        int rb;
        int sel;
        int v;
        rb  = effective_bound(row_cnt_reg, MAX_ROWS);
        sel = $urandom_range(99);
        if (sel < 30)      v = $urandom_range(4);
        else if (sel < 60) v = rb - 3 + $urandom_range(5);
        else if (sel < 75) v = $urandom_range(MAX_ROWS - 1);
        else               v = rb / 2 - 2 + $urandom_range(4);
        return ROW_W'(clip_to_edge(v, MAX_ROWS));
    endfunction

    function automatic logic [COL_W-1:0] pick_col();
        int cb;
        int sel;
        int v;
        cb  = effective_bound(col_cnt_reg, MAX_COLS);
        sel = $urandom_range(99);
        if (sel < 30)      v = $urandom_range(3);
        else if (sel < 60) v = cb - 3 + $urandom_range(5);
        else               v = $urandom_range(MAX_COLS - 1);
        return COL_W'(clip_to_edge(v, MAX_COLS));
    endfunction

    task automatic note_mismatch(string what, longint want, longint got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // Compare each popped word with the oldest expected result
    always @(posedge i_clk) begin
        conv_result_t want;
        if (i_rst_n && pop && !empty) begin
            if (conv_expect_q.size() == 0) begin
                note_mismatch("unexpected word (row)", -1, o_out_row);
            end else begin
                want = conv_expect_q.pop_front();
                if (o_out_row !== want.row)
                    note_mismatch("out_row", want.row, o_out_row);
                if (o_out_col !== want.col)
                    note_mismatch("out_col", want.col, o_out_col);
                if (o_sum !== want.sum)
                    note_mismatch("sum", $signed(want.sum), $signed(o_sum));
            end
        end
    end

    always @(posedge i_clk) begin
        pop <= (pop_stall_pct == 0) || ($urandom_range(99) >= pop_stall_pct);
    end

    // Send one word and update the shadow state when it is accepted
    task automatic send_word(logic [ACTION_W-1:0] act, logic [TAP_IDX_W-1:0] tap,
                             logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                             logic signed [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_action    <= act;
        i_tap_index <= tap;
        i_row       <= row;
        i_col       <= col;
        i_value     <= value;
        do @(posedge i_clk); while (full);
        case (act)
            ACT_TAP: begin
                if (tap < TAPS) begin
                    tap_mem[tap] = value;
                    n_write++;
                end else begin
                    n_ignored++;
                end
            end
            ACT_PIX: begin
                pix_mem[{row, col}]     = value;
                pix_written[{row, col}] = 1'b1;
                n_write++;
            end
            ACT_CONV: begin
                conv_expect_q.push_back('{row, col, predict_conv_sum(row, col)});
                n_conv++;
            end
            default: n_ignored++;
        endcase
    endtask

    // Write any element of the window that has never been written, then request
    task automatic request_conv(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        int rb;
        int cb;
        int x;
        int y;
        rb = effective_bound(row_cnt_reg, MAX_ROWS);
        cb = effective_bound(col_cnt_reg, MAX_COLS);
        for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE; c++) begin
                x = clip_to_edge(row + r - KHALF, rb);
                y = clip_to_edge(col + c - KHALF, cb);
                if (!pix_written[x*MAX_COLS + y])
                    send_word(ACT_PIX, TAP_IDX_W'($urandom()), ROW_W'(x), COL_W'(y),
                              rand16());
            end
        end
        send_word(ACT_CONV, TAP_IDX_W'($urandom()), row, col, rand16());
    endtask

    task automatic quiesce();
        push <= 1'b0;
        @(posedge i_clk);
        while (conv_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leave valid high; the caller drops it after the last write
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ROW_COUNT) row_cnt_reg = data[ROW_CNT_W-1:0];
        else                      col_cnt_reg = data[COL_CNT_W-1:0];
    endtask

    task automatic set_bounds(int rows, int cols);
        quiesce();
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows));
        write_reg(CFG_COL_COUNT, CFG_DATA_W'(cols));
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic load_taps(logic signed [VALUE_W-1:0] fill, logic use_fill);
        for (int t = 0; t < TAPS; t++)
            send_word(ACT_TAP, TAP_IDX_W'(t), ROW_W'($urandom()), COL_W'($urandom()),
                      use_fill ? fill : rand16());
    endtask

    task automatic test_kernel_and_corners();
        set_bounds(MAX_ROWS, MAX_COLS);
        load_taps('0, 1'b0);
        send_word(ACT_TAP, 6'd0, 10'd0, 4'd0, 16'sh8000);
        send_word(ACT_TAP, 6'd24, 10'd1023, 4'd15, 16'sh7fff);
        send_word(ACT_PIX, 6'd63, 10'd0, 4'd0, 16'sh7fff);
        send_word(ACT_PIX, 6'd0, 10'd1023, 4'd15, 16'sh8000);
        request_conv(10'd0, 4'd0);
        request_conv(10'd1023, 4'd15);
        request_conv(10'd512, 4'd8);
    endtask

    task automatic test_ignored_words();
        send_word(ACT_NONE, 6'd63, 10'd1023, 4'd15, 16'sh7fff);
        send_word(ACT_TAP, 6'd25, 10'd5, 4'd5, 16'sh8000);
        send_word(ACT_TAP, 6'd63, 10'd0, 4'd0, 16'sh7fff);
        send_word(ACT_TAP, 6'd32, 10'd1, 4'd1, rand16());
        request_conv(10'd0, 4'd0);
    endtask

    // A bound of zero acts as one: every neighbor clamps to element (0, 0); a bound of one follows
    task automatic test_one_element_bound();
        set_bounds(0, 0);
        load_taps(16'sh8000, 1'b1);
        send_word(ACT_PIX, 6'd0, 10'd0, 4'd0, 16'sh8000);
        request_conv(10'd0, 4'd0);
        request_conv(10'd1023, 4'd15);
        send_word(ACT_PIX, 6'd0, 10'd0, 4'd0, 16'sh7fff);
        request_conv(10'd700, 4'd3);
        set_bounds(1, 1);
        request_conv(10'd2, 4'd2);
    endtask

    task automatic test_bound_saturation();
        set_bounds(2047, 31);
        load_taps('0, 1'b0);
        request_conv(10'd1023, 4'd15);
        request_conv(10'd1022, 4'd14);
        request_conv(10'd0, 4'd15);
        set_bounds(MAX_ROWS, MAX_COLS);
        request_conv(10'd1023, 4'd0);
    endtask

    task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
        int sel;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(99);
            if (sel < 35)
                request_conv(pick_row(), pick_col());
            else if (sel < 65)
                send_word(ACT_PIX, TAP_IDX_W'($urandom()), pick_row(), pick_col(), rand16());
            else if (sel < 85)
                send_word(ACT_TAP, TAP_IDX_W'($urandom_range(TAPS - 1)),
                          ROW_W'($urandom()), COL_W'($urandom()), rand16());
            else if (sel < 93)
                send_word(ACT_TAP, TAP_IDX_W'($urandom_range(63, TAPS)),
                          ROW_W'($urandom()), COL_W'($urandom()), rand16());
            else
                send_word(ACT_NONE, TAP_IDX_W'($urandom()), ROW_W'($urandom()),
                          COL_W'($urandom()), rand16());
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_ROWS*MAX_COLS; i++) begin
            pix_mem[i]     = '0;
            pix_written[i] = 1'b0;
        end
        for (int t = 0; t < TAPS; t++) tap_mem[t] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_kernel_and_corners();
        test_ignored_words();
        test_one_element_bound();
        test_bound_saturation();

        // Window fills add words on top of these counts
        set_bounds(MAX_ROWS, MAX_COLS);
        test_random_traffic(50, 0, 0);
        set_bounds($urandom_range(40, 2), $urandom_range(15, 2));
        test_random_traffic(50, 72, 0);
        set_bounds($urandom_range(2047), $urandom_range(31));
        test_random_traffic(50, 0, 72);
        set_bounds(5, MAX_COLS);
        test_random_traffic(50, 22, 22);

        pop_stall_pct = 0;
        quiesce();
        $display("covered %0d convolutions, %0d tap/element writes, %0d ignored words",
                 n_conv, n_write, n_ignored);
        $display("across %0d bound settings with mixed input gaps and output stalls; %0d errors",
                 n_settings, err_count);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/cce_pkg.sv
src/cce_front.sv
src/cce_back.sv
src/conv2d_clamp_edge_core.sv
test/tb_conv2d_clamp_edge_core.sv
